// ===== hw/rtl/icps_pkg.sv =====
// ============================================================================
// Idle connection pool stack package
// Shared widths, default parameter values, opcodes and the command bundle
// that the controller drives into the datapath.
// ============================================================================
package icps_pkg;

  // Fixed widths of the request and response fields.
  localparam int OPCODE_BITS  = 2;
  localparam int CONN_ID_BITS = 16;
  localparam int CAP_BITS     = 5;

  // Defaults for the top-level parameters.
  localparam int POOL_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF    = 16;

  // Capacity after reset.
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(1);

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLOSE   = 2'd2
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the accepted request
    logic lookup;   // compare the cell row and pick out the oldest entry
    logic apply;    // update the cell row and load the output register
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/icps_if.sv =====
// ============================================================================
// Idle connection pool stack channels
// Valid/ready channels for requests into the pool and responses out of it.
// ============================================================================
interface icps_req_if import icps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPCODE_BITS-1:0]  opcode;
  logic [CONN_ID_BITS-1:0] conn_id;
  logic                    has_connection;
  logic                    failed;

  modport source (output valid, opcode, conn_id, has_connection, failed, input ready);
  modport sink   (input valid, opcode, conn_id, has_connection, failed, output ready);
endinterface

interface icps_rsp_if import icps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    granted;
  logic [CONN_ID_BITS-1:0] grant_id;
  logic                    close_req;
  logic [CONN_ID_BITS-1:0] close_id;
  logic                    unknown;

  modport source (output valid, granted, grant_id, close_req, close_id, unknown, input ready);
  modport sink   (input valid, granted, grant_id, close_req, close_id, unknown, output ready);
endinterface

// ===== hw/rtl/icps_ctrl.sv =====
// ============================================================================
// Idle connection pool stack controller
// Steps each request through capture, lookup and apply, and owns the
// response valid flag.
// ============================================================================
module icps_ctrl import icps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_APPLY  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.lookup  = (state == S_LOOKUP);
    // The apply step waits while the previous response is still unclaimed.
    cmd.apply   = (state == S_APPLY) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (cmd.apply) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.apply) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/icps_dp.sv =====
// ============================================================================
// Idle connection pool stack datapath
// A row of handle cells with per-cell compare, plus the capacity register,
// fill count and response register.
// ============================================================================
module icps_dp import icps_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  input  logic [OPCODE_BITS-1:0]  opcode,
  input  logic [CONN_ID_BITS-1:0] conn_id,
  input  logic                    has_connection,
  input  logic                    failed,
  input  logic                    cfg_we,
  input  logic [CAP_BITS-1:0]     cfg_wdata,
  output logic                    granted,
  output logic [CONN_ID_BITS-1:0] grant_id,
  output logic                    close_req,
  output logic [CONN_ID_BITS-1:0] close_id,
  output logic                    unknown
);

  localparam int CntBits  = $clog2(POOL_DEPTH + 1);
  localparam int CmpBits  = (CntBits > CAP_BITS) ? CntBits : CAP_BITS;
  localparam int CopyBits = (ID_BITS < CONN_ID_BITS) ? ID_BITS : CONN_ID_BITS;

  // Log-depth prefix OR: bit j is set when any bit at or below j is set.
  function automatic logic [POOL_DEPTH-1:0] prefix_or(input logic [POOL_DEPTH-1:0] v);
    logic [POOL_DEPTH-1:0] r;
    r = v;
    for (int s = 1; s < POOL_DEPTH; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

  logic [CAP_BITS-1:0] capacity;
  logic [CntBits-1:0]  count;
  logic [CntBits-1:0]  count_next;
  logic [ID_BITS-1:0]  row    [POOL_DEPTH];
  logic [ID_BITS-1:0]  prev_e [POOL_DEPTH];
  logic [ID_BITS-1:0]  next_e [POOL_DEPTH];

  // Captured request.
  logic [OPCODE_BITS-1:0] op_q;
  logic [ID_BITS-1:0]     id_q;
  logic                   pool_ok_q;

  // Lookup results.
  logic [POOL_DEPTH-1:0] valid;
  logic [POOL_DEPTH-1:0] last;
  logic [POOL_DEPTH-1:0] hit;
  logic [POOL_DEPTH-1:0] hit_q;
  logic [ID_BITS-1:0]    tail;
  logic [ID_BITS-1:0]    tail_q;
  logic [CmpBits-1:0]    cap_ext;
  logic [CmpBits-1:0]    cap_eff;
  logic                  full;
  logic                  full_q;

  // Apply step.
  logic [POOL_DEPTH-1:0]   thr;
  logic                    found;
  logic                    shift_back;
  logic [POOL_DEPTH-1:0]   fwd_mask;
  logic                    granted_next;
  logic [CONN_ID_BITS-1:0] grant_id_next;
  logic                    close_req_next;
  logic [CONN_ID_BITS-1:0] close_id_next;
  logic                    unknown_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= opcode;
      id_q      <= ID_BITS'(conn_id[CopyBits-1:0]);
      pool_ok_q <= has_connection && !failed;
    end
  end

  // Occupied cells form a thermometer below the count; the oldest handle sits
  // in the last occupied cell.
  always_comb begin
    for (int j = 0; j < POOL_DEPTH; j++) begin
      valid[j] = (CntBits'(j) < count);
    end
    last = valid & ~(valid >> 1);
    tail = '0;
    for (int j = 0; j < POOL_DEPTH; j++) begin
      hit[j] = valid[j] && (row[j] == id_q);
      tail   = tail | (row[j] & {ID_BITS{last[j]}});
    end
  end

  // A capacity of zero acts as one, and one above the depth as the depth.
  always_comb begin
    cap_ext = CmpBits'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CmpBits'(1);
    end else if (cap_ext > CmpBits'(POOL_DEPTH)) begin
      cap_eff = CmpBits'(POOL_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
    full = (CmpBits'(count) >= cap_eff) && (count != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_q  <= hit;
      tail_q <= tail;
      full_q <= full;
    end
  end

  always_comb begin
    thr            = prefix_or(hit_q);
    found          = |hit_q;
    shift_back     = 1'b0;
    fwd_mask       = '0;
    count_next     = count;
    granted_next   = 1'b0;
    grant_id_next  = '0;
    close_req_next = 1'b0;
    close_id_next  = '0;
    unknown_next   = 1'b0;
    case (opcode_t'(op_q))
      OP_ACQUIRE: begin
        if (count != '0) begin
          granted_next  = 1'b1;
          grant_id_next = CONN_ID_BITS'(row[0][CopyBits-1:0]);
          fwd_mask      = '1;
          count_next    = count - CntBits'(1);
        end
      end
      OP_RELEASE: begin
        if (pool_ok_q) begin
          shift_back = 1'b1;
          if (full_q) begin
            // Evict the oldest handle; the count stays where it is.
            close_req_next = 1'b1;
            close_id_next  = CONN_ID_BITS'(tail_q[CopyBits-1:0]);
          end else begin
            count_next = count + CntBits'(1);
          end
        end
      end
      OP_CLOSE: begin
        close_req_next = 1'b1;
        close_id_next  = CONN_ID_BITS'(id_q[CopyBits-1:0]);
        unknown_next   = !found;
        if (found) begin
          // Cells from the most recent match onwards close up the gap.
          fwd_mask   = thr;
          count_next = count - CntBits'(1);
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar j = 0; j < POOL_DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign prev_e[j] = id_q;
    end else begin : g_inner_prev
      assign prev_e[j] = row[j-1];
    end
    if (j == POOL_DEPTH - 1) begin : g_last
      assign next_e[j] = row[j];
    end else begin : g_inner_next
      assign next_e[j] = row[j+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        if (shift_back) begin
          row[j] <= prev_e[j];
        end else if (fwd_mask[j]) begin
          row[j] <= next_e[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      granted   <= granted_next;
      grant_id  <= grant_id_next;
      close_req <= close_req_next;
      close_id  <= close_id_next;
      unknown   <= unknown_next;
    end
  end

endmodule

// ===== hw/rtl/idle_connection_pool_stack_unit.sv =====
// A request accepted into the capture registers goes through lookup and then
// apply, which loads the output register once any earlier response is taken.
// The controller takes no new request until the current one has finished the
// lookup and apply steps of the shared cell row. Reset (synchronous, rst high)
// empties the pool, sets capacity to one and drops the response valid; handle
// cells keep their contents and need no pass.
// ============================================================================
// Idle connection pool stack
// A bounded stack of idle connection handles ordered from most to least
// recently released, with acquire, release with eviction, and close notices.
// ============================================================================
module idle_connection_pool_stack_unit import icps_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  icps_req_if.sink            req,
  icps_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_wdata
);

  // Commands from the controller. The controller takes a request only when
  // it is idle, then steps through lookup, in which every cell compares its
  // handle against the request and the oldest occupied cell is picked out,
  // and apply, in which the row shifts and the response is loaded. The apply
  // step holds off while an earlier response is still waiting, so the output
  // register separates the two channels and a new request can be taken while
  // a response waits to be collected.
  ctrl_cmd_t cmd;

  icps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the capacity register, the fill count and the row of
  // handle cells. Cell zero holds the most recently released handle. A
  // release that pools its handle shifts the whole row back by one and writes
  // the new handle in front; when the pool is at capacity the oldest handle,
  // captured during lookup, is reported for closing and the count is unchanged.
  // An acquire and a matched close notice shift cells forward from the removed place.
  icps_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .opcode         (req.opcode),
    .conn_id        (req.conn_id),
    .has_connection (req.has_connection),
    .failed         (req.failed),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .granted        (rsp.granted),
    .grant_id       (rsp.grant_id),
    .close_req      (rsp.close_req),
    .close_id       (rsp.close_id),
    .unknown        (rsp.unknown)
  );

endmodule

// ===== hw/rtl/icps_checker.sv =====
// ============================================================================
// Idle connection pool stack checker
// Port-level checks on the request and response channels, bound to the top.
// ============================================================================
module icps_checker import icps_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic                    granted,
  input logic [CONN_ID_BITS-1:0] grant_id,
  input logic                    close_req,
  input logic [CONN_ID_BITS-1:0] close_id,
  input logic                    unknown
);

  // A waiting response stays offered until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response withdrawn before it was taken");

  // Requests are handled one at a time: no request is taken in the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in flight");

  // A grant and a close never come in the same response.
  a_grant_xor_close: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(granted && close_req))
    else $error("response both grants and closes a handle");

  // Without a grant the granted handle reads as zero.
  a_grant_id_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !granted |-> grant_id == '0)
    else $error("grant handle non-zero without a grant");

  // Without a close request the close handle is zero and no unknown flag is set.
  a_close_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !close_req |-> (close_id == '0) && !unknown)
    else $error("close fields set without a close request");

endmodule

bind idle_connection_pool_stack_unit icps_checker u_icps_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .granted   (rsp.granted),
  .grant_id  (rsp.grant_id),
  .close_req (rsp.close_req),
  .close_id  (rsp.close_id),
  .unknown   (rsp.unknown)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Idle connection pool stack testbench
// Drives requests into the pool through valid/ready channels and checks every
// response against an independent model or a pinned row. A short table
// of hand picked requests comes first. Random phases follow, each with its
// own capacity setting, while the sender and the receiver stall at random.
// ----------------------------------------------------------------------------
module tb;
  import icps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH   = POOL_DEPTH_DEF;
  localparam int ID_BITS      = ID_BITS_DEF;
  localparam int DIR_ROWS     = 25;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int ID_SET_SIZE  = 24;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 400000;

  // Opcode 3 has no meaning in the block and must be ignored.
  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]  opcode;
    logic [CONN_ID_BITS-1:0] conn_id;
    logic                    has_conn;
    logic                    failed;
  } pool_req_t;

  typedef struct packed {
    logic                    granted;
    logic [CONN_ID_BITS-1:0] grant_id;
    logic                    close_req;
    logic [CONN_ID_BITS-1:0] close_id;
    logic                    unknown;
  } pool_rsp_t;

  localparam pool_rsp_t NO_RSP = '0;

  // One row of the directed table. When set_cap is high the capacity register
  // is rewritten, with the pool idle, before the request goes out. When pinned
  // is high the response is the one typed into the row.
  typedef struct {
    bit                      set_cap;
    logic [CAP_BITS-1:0]     cap;
    logic [OPCODE_BITS-1:0]  op;
    logic [CONN_ID_BITS-1:0] id;
    logic                    has_conn;
    logic                    failed;
    bit                      pinned;
    pool_rsp_t               rsp;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  icps_req_if req_ch ();
  icps_rsp_if rsp_ch ();

  idle_connection_pool_stack_unit #(
    .POOL_DEPTH(POOL_DEPTH),
    .ID_BITS   (ID_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Model of the pool: position 0 holds the most recently released handle.
  logic [CONN_ID_BITS-1:0] pool_mirror [POOL_DEPTH];
  int                      held;
  logic [CAP_BITS-1:0]     cap_mirror;

  // Responses still owed by the block, oldest first.
  pool_rsp_t rsp_due [$];

  // What the sender is offering right now, read by the monitor on acceptance.
  bit        offer_pinned;
  pool_rsp_t offer_pin_rsp;

  int mismatches;
  int cycles;
  int burst_left;
  int hold_asked;
  int hold_done;
  int n_req, n_grant, n_miss, n_evict, n_pooled, n_not_pooled;
  int n_matched, n_unknown, n_ignored;

  logic [CONN_ID_BITS-1:0] id_set [ID_SET_SIZE];
  logic [CAP_BITS-1:0]     phase_cap [PHASES];
  dir_row_t                steps [DIR_ROWS];

  // Removes the handle at pos and closes up the gap behind it.
  function automatic void drop_at(input int pos);
    for (int i = pos; i < held - 1; i++) pool_mirror[i] = pool_mirror[i + 1];
    held--;
  endfunction

  // Moves the first n handles one place back and puts id at the front.
  function automatic void push_front(input int n, input logic [CONN_ID_BITS-1:0] id);
    for (int i = n; i > 0; i--) pool_mirror[i] = pool_mirror[i - 1];
    pool_mirror[0] = id;
  endfunction

  // Works out the response to one accepted request and updates the model.
  function automatic pool_rsp_t pool_step(input pool_req_t r);
    pool_rsp_t o;
    int        eff;
    int        hit;
    o   = '0;
    eff = int'(cap_mirror);
    // A capacity of zero behaves as one, anything above the depth as the depth.
    if (eff < 1) eff = 1;
    if (eff > POOL_DEPTH) eff = POOL_DEPTH;
    case (r.opcode)
      OP_ACQUIRE: begin
        if (held > 0) begin
          o.granted  = 1'b1;
          o.grant_id = pool_mirror[0];
          drop_at(0);
        end
      end
      OP_RELEASE: begin
        if (r.has_conn && !r.failed) begin
          // At or above capacity only the single oldest handle goes, so a
          // lowered capacity leaves the count where it was.
          if (held >= eff) begin
            o.close_req = 1'b1;
            o.close_id  = pool_mirror[held - 1];
            push_front(held - 1, r.conn_id);
          end else begin
            push_front(held, r.conn_id);
            held++;
          end
        end
      end
      OP_CLOSE: begin
        // Only the most recent copy of a duplicated handle is removed.
        hit = -1;
        for (int i = 0; i < held; i++)
          if (hit < 0 && pool_mirror[i] == r.conn_id) hit = i;
        if (hit >= 0) drop_at(hit);
        o.close_req = 1'b1;
        o.close_id  = r.conn_id;
        o.unknown   = (hit < 0);
      end
      default: ;
    endcase
    return o;
  endfunction

  // Builds a random request. While filling, releases dominate and the pool
  // climbs to its capacity; while draining, acquires empty it again.
  function automatic pool_req_t make_request(input bit filling);
    pool_req_t r;
    int        roll;
    roll       = $urandom_range(0, 99);
    r.has_conn = 1'($urandom_range(0, 1));
    r.failed   = 1'($urandom_range(0, 1));
    if (filling)
      r.opcode = (roll < 60) ? OP_RELEASE : (roll < 75) ? OP_ACQUIRE :
                 (roll < 95) ? OP_CLOSE : OP_UNUSED;
    else
      r.opcode = (roll < 50) ? OP_ACQUIRE : (roll < 75) ? OP_RELEASE :
                 (roll < 95) ? OP_CLOSE : OP_UNUSED;
    if (r.opcode == OP_RELEASE && $urandom_range(0, 99) < 85) begin
      r.has_conn = 1'b1;
      r.failed   = 1'b0;
    end
    // Close notices mostly name a handle that is pooled at the moment, so
    // that hits at every depth are reached; the rest come from a small set
    // of handles, which also makes duplicates common.
    if (r.opcode == OP_CLOSE && held > 0 && $urandom_range(0, 9) < 6)
      r.conn_id = pool_mirror[$urandom_range(0, held - 1)];
    else if ($urandom_range(0, 9) < 7)
      r.conn_id = id_set[$urandom_range(0, ID_SET_SIZE - 1)];
    else
      r.conn_id = CONN_ID_BITS'($urandom);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Offers one request from the falling edge on and returns at the rising
  // edge that accepts it. Valid stays high for a following request.
  task automatic offer(input pool_req_t r, input bit pinned, input pool_rsp_t pin);
    @(negedge clk);
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= r.opcode;
    req_ch.conn_id        <= r.conn_id;
    req_ch.has_connection <= r.has_conn;
    req_ch.failed         <= r.failed;
    offer_pinned          <= pinned;
    offer_pin_rsp         <= pin;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Leaves the request channel idle for a gap whose length is given by n.
  task automatic sender_gap(input int n);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Bursts of random length with random gaps; now and then a long burst.
  task automatic pace();
    if (burst_left == 0) begin
      sender_gap($urandom_range(1, 7));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) :
                   $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Waits until every response is in, lets the block settle and then writes
  // the capacity register.
  task automatic set_capacity(input logic [CAP_BITS-1:0] value);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d responses outstanding",
               cycles, rsp_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted
  // response. Both channels are sampled at the rising edge, where the driven
  // values have been stable since the falling edge.
  always @(posedge clk) begin : monitor
    pool_req_t acc;
    pool_rsp_t want;
    pool_rsp_t got;
    if (rst) begin
      held       = 0;
      cap_mirror = CAP_RESET;
    end else begin
      if (cfg_we) cap_mirror = cfg_wdata;
      if (req_ch.valid && req_ch.ready) begin
        acc  = {req_ch.opcode, req_ch.conn_id, req_ch.has_connection, req_ch.failed};
        want = pool_step(acc);
        n_req++;
        case (acc.opcode)
          OP_ACQUIRE: if (want.granted) n_grant++; else n_miss++;
          OP_RELEASE: begin
            if (want.close_req) n_evict++;
            else if (acc.has_conn && !acc.failed) n_pooled++;
            else n_not_pooled++;
          end
          OP_CLOSE:   if (want.unknown) n_unknown++; else n_matched++;
          default:    n_ignored++;
        endcase
        rsp_due.push_back(offer_pinned ? offer_pin_rsp : want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.granted, rsp_ch.grant_id, rsp_ch.close_req, rsp_ch.close_id,
               rsp_ch.unknown};
        if (rsp_due.size() == 0) begin
          report_mismatch("response with no request outstanding", 32'(got), 32'd0);
        end else begin
          want = rsp_due.pop_front();
          if (got.granted !== want.granted)
            report_mismatch("granted", 32'(got.granted), 32'(want.granted));
          if (got.grant_id !== want.grant_id)
            report_mismatch("grant_id", 32'(got.grant_id), 32'(want.grant_id));
          if (got.close_req !== want.close_req)
            report_mismatch("close_req", 32'(got.close_req), 32'(want.close_req));
          if (got.close_id !== want.close_id)
            report_mismatch("close_id", 32'(got.close_id), 32'(want.close_id));
          if (got.unknown !== want.unknown)
            report_mismatch("unknown", 32'(got.unknown), 32'(want.unknown));
        end
      end
    end
  end

  // Receiver: switches at random between stall patterns, and
  // serves a long hold-off whenever the sender asks for one. During a
  // hold-off the sender keeps offering, so the block fills and stops taking
  // requests.
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    rsp_ch.ready = 1'b0;
    mode_left    = 0;
    tick         = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_asked != hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= (tick % 4) != 0;
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : sender
    pool_req_t r;
    bit        filling;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_ACQUIRE;
    req_ch.conn_id        = '0;
    req_ch.has_connection = 1'b0;
    req_ch.failed         = 1'b0;
    offer_pinned          = 1'b0;
    offer_pin_rsp         = NO_RSP;
    mismatches            = 0;
    cycles                = 0;
    burst_left            = 0;
    hold_asked            = 0;
    hold_done             = 0;
    {n_req, n_grant, n_miss, n_evict, n_pooled, n_not_pooled} = '0;
    {n_matched, n_unknown, n_ignored} = '0;

    id_set[0] = '0;
    id_set[1] = '1;
    for (int i = 2; i < ID_SET_SIZE; i++) id_set[i] = CONN_ID_BITS'($urandom);

    // Capacity per random phase: the nominal extremes, values that clamp, and
    // two random settings at the end.
    phase_cap = '{5'd16, 5'd31, 5'd0, 5'd17, 5'd1, 5'd2, 5'd0, 5'd0};
    phase_cap[6] = CAP_BITS'($urandom_range(0, 31));
    phase_cap[7] = CAP_BITS'($urandom_range(0, 31));

    // Directed requests. The first block runs at the capacity of one left by
    // reset: a miss on the empty pool, an eviction at capacity one, requests
    // that are not pooled, the unused opcode and a notice for an absent handle.
    // Later rows are checked against the model: duplicate handles, capacity
    // lowered below the count, a capacity of zero and one above the depth.
    steps = '{
      '{0, 5'd0,  OP_ACQUIRE, 16'h0000, 1'b0, 1'b0, 1, NO_RSP},
      '{0, 5'd0,  OP_RELEASE, 16'hFFFF, 1'b1, 1'b0, 1, NO_RSP},
      '{0, 5'd0,  OP_RELEASE, 16'h0000, 1'b1, 1'b0, 1,
        '{1'b0, 16'h0000, 1'b1, 16'hFFFF, 1'b0}},
      '{0, 5'd0,  OP_ACQUIRE, 16'hFFFF, 1'b1, 1'b1, 1,
        '{1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0}},
      '{0, 5'd0,  OP_RELEASE, 16'h2222, 1'b0, 1'b0, 1, NO_RSP},
      '{0, 5'd0,  OP_RELEASE, 16'h3333, 1'b1, 1'b1, 1, NO_RSP},
      '{0, 5'd0,  OP_UNUSED,  16'hFFFF, 1'b1, 1'b1, 1, NO_RSP},
      '{0, 5'd0,  OP_CLOSE,   16'h1234, 1'b0, 1'b0, 1,
        '{1'b0, 16'h0000, 1'b1, 16'h1234, 1'b1}},
      '{1, 5'd16, OP_RELEASE, 16'h0101, 1'b1, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_RELEASE, 16'h0202, 1'b1, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_RELEASE, 16'h0101, 1'b1, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_RELEASE, 16'h0303, 1'b1, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_CLOSE,   16'h0101, 1'b0, 1'b0, 0, NO_RSP},
      '{1, 5'd2,  OP_RELEASE, 16'h0404, 1'b1, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_ACQUIRE, 16'h0000, 1'b0, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_ACQUIRE, 16'h0000, 1'b0, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_ACQUIRE, 16'h0000, 1'b0, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_ACQUIRE, 16'h0000, 1'b0, 1'b0, 0, NO_RSP},
      '{1, 5'd0,  OP_RELEASE, 16'h8000, 1'b1, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_RELEASE, 16'h7FFF, 1'b1, 1'b0, 0, NO_RSP},
      '{1, 5'd31, OP_RELEASE, 16'h1111, 1'b1, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_CLOSE,   16'h7FFF, 1'b0, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_CLOSE,   16'hFFFF, 1'b1, 1'b1, 0, NO_RSP},
      '{0, 5'd0,  OP_ACQUIRE, 16'h0000, 1'b0, 1'b0, 0, NO_RSP},
      '{0, 5'd0,  OP_CLOSE,   16'h1111, 1'b0, 1'b0, 0, NO_RSP}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The directed part runs back to back on the sending side.
    foreach (steps[i]) begin
      if (steps[i].set_cap) set_capacity(steps[i].cap);
      r = {steps[i].op, steps[i].id, steps[i].has_conn, steps[i].failed};
      offer(r, steps[i].pinned, steps[i].rsp);
    end

    // Random phases, switching at random between filling and draining the pool.
    filling = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) filling = ($urandom_range(0, 2) != 0) ? ~filling : filling;
        // One long receiver hold-off early in the phase at the largest depth.
        if (p == 1 && k == 20) hold_asked++;
        pace();
        offer(make_request(filling), 1'b0, NO_RSP);
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests: %0d grants, %0d misses, %0d pooled, %0d evictions, %0d not pooled",
             n_req, n_grant, n_miss, n_pooled, n_evict, n_not_pooled);
    $display("close notices %0d matched and %0d unknown, %0d unused opcodes, %0d mismatches",
             n_matched, n_unknown, n_ignored, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
